@@ rtl/skhie_pkg.sv @@
// ----------------------------------------------------------------------------
// skhie_pkg
// shared constants and types of the string key hash insert engine
// ----------------------------------------------------------------------------
package skhie_pkg;

  localparam int CAPACITY      = 1024;
  localparam int MAX_KEY_BYTES = 16;
  localparam int MIN_SIZE      = 10;

  localparam int BASE_SIZE = (MIN_SIZE < CAPACITY) ? MIN_SIZE : CAPACITY;

  localparam int SLOT_W   = $clog2(CAPACITY);
  localparam int ADDR_W   = SLOT_W + 1;
  localparam int DEPTH    = 2 * CAPACITY;
  localparam int SIZE_W   = 11;
  localparam int LEN_W    = $clog2(MAX_KEY_BYTES + 1);
  localparam int KIDX_W   = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
  localparam int SUM_W    = $clog2(MAX_KEY_BYTES * 255 + 1);
  localparam int VALUE_W  = 32;

  typedef logic [MAX_KEY_BYTES-1:0][7:0] key_t;

  typedef struct packed {
    logic               valid;
    logic [SUM_W-1:0]   sum;
    logic [VALUE_W-1:0] value;
    key_t               key;
  } entry_t;

endpackage

@@ rtl/skhie_slot_mem.sv @@
// ----------------------------------------------------------------------------
// skhie_slot_mem
// slot memory, both banks, one write and one registered read port
// ----------------------------------------------------------------------------
module skhie_slot_mem (
  input  logic                      clk,
  input  logic                      we,
  input  logic [skhie_pkg::ADDR_W-1:0] waddr,
  input  skhie_pkg::entry_t         wdata,
  input  logic [skhie_pkg::ADDR_W-1:0] raddr,
  output skhie_pkg::entry_t         rdata
);

  skhie_pkg::entry_t mem [skhie_pkg::DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/skhie_mod_unit.sv @@
// ----------------------------------------------------------------------------
// skhie_mod_unit
// byte sum modulo table size, one restoring step per cycle
// ----------------------------------------------------------------------------
module skhie_mod_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [skhie_pkg::SUM_W-1:0]  dividend,
  input  logic [skhie_pkg::SIZE_W-1:0] divisor,
  output logic                         done,
  output logic [skhie_pkg::SLOT_W-1:0] remainder
);

  localparam int CNT_W = $clog2(skhie_pkg::SUM_W + 1);

  logic [skhie_pkg::SUM_W-1:0]  dvd_r;
  logic [skhie_pkg::SIZE_W-1:0] dvs_r;
  logic [skhie_pkg::SIZE_W-1:0] rem_r;
  logic [CNT_W-1:0]             cnt_r;
  logic                         busy_r;
  logic                         done_r;
  logic [skhie_pkg::SIZE_W-1:0] shifted;

  // remainder stays below divisor, so its top bit is always zero
  assign shifted = {rem_r[skhie_pkg::SIZE_W-2:0], dvd_r[skhie_pkg::SUM_W-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(skhie_pkg::SUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dvs_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[skhie_pkg::SUM_W-2:0], 1'b0};
      rem_r <= (shifted >= dvs_r) ? shifted - dvs_r : shifted;
    end
  end

  assign done      = done_r;
  assign remainder = rem_r[skhie_pkg::SLOT_W-1:0];

endmodule

@@ rtl/string_key_hash_insert_engine.sv @@
// ----------------------------------------------------------------------------
// string_key_hash_insert_engine
// open addressing hash table with linear probing, keys arrive a byte per beat
// ----------------------------------------------------------------------------
//  channel  | ports                                          | handshake
//  ---------+------------------------------------------------+------------------
//  input    | in_func in_key_byte in_key_last in_value       | start & !busy
//  result   | out_is_new out_table_full out_entry_count      | out_valid strobe
//           | out_table_size                                 |
//
//  a key byte that is not last leaves the block idle; a last byte or a clear is
//  followed by a busy stretch set by the slot memory walk: the modulo unit,
//  then a read and a check per probed slot and a post state, plus a rehash
//  when the table gets half full (a sweep of the new size, a read and a check
//  per old slot, and one place per stored key); a clear sweeps the slots in use, one per cycle
//  after reset the block sweeps MIN_SIZE slots of bank 0 before taking a beat
//  the receiver cannot stall: out_valid is high for one cycle per result
// ----------------------------------------------------------------------------
module string_key_hash_insert_engine (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_func,
  input  logic [7:0]  in_key_byte,
  input  logic        in_key_last,
  input  logic signed [31:0] in_value,
  output logic        out_valid,
  output logic        out_is_new,
  output logic        out_table_full,
  output logic [10:0] out_entry_count,
  output logic [10:0] out_table_size
);

  localparam int SLOT_W = skhie_pkg::SLOT_W;
  localparam int SIZE_W = skhie_pkg::SIZE_W;
  localparam int SUM_W  = skhie_pkg::SUM_W;
  localparam int LEN_W  = skhie_pkg::LEN_W;
  localparam int NS_W   = SIZE_W + 2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SWEEP,
    S_MOD_GO,
    S_MOD_WAIT,
    S_PROBE_RD,
    S_PROBE_CHK,
    S_POST,
    S_RH_RD,
    S_RH_CHK
  } state_t;

  state_t state_r, state_nxt;
  state_t ret_r, ret_nxt;           // where a sweep goes when it ends

  // key gathering
  skhie_pkg::key_t  key_r, key_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;

  // table status
  logic [SIZE_W-1:0] count_r, count_nxt;
  logic [SIZE_W-1:0] size_r, size_nxt;
  logic              bank_r, bank_nxt;

  // the entry being placed
  skhie_pkg::key_t   cur_key_r, cur_key_nxt;
  logic [SUM_W-1:0]  cur_sum_r, cur_sum_nxt;
  logic [31:0]       cur_val_r, cur_val_nxt;
  logic              tgt_bank_r, tgt_bank_nxt;
  logic [SIZE_W-1:0] tgt_size_r, tgt_size_nxt;
  logic              rehash_r, rehash_nxt;
  logic [SLOT_W-1:0] idx_r, idx_nxt;
  logic [SIZE_W-1:0] probes_r, probes_nxt;
  logic              is_new_r, is_new_nxt;
  logic              full_r, full_nxt;

  // sweep and rehash scan
  logic              sw_bank_r, sw_bank_nxt;
  logic [SLOT_W-1:0] sw_idx_r, sw_idx_nxt;
  logic [SIZE_W-1:0] sw_lim_r, sw_lim_nxt;
  logic [SLOT_W-1:0] scan_r, scan_nxt;

  // result registers
  logic              ov_r, ov_nxt;
  logic              o_new_r, o_new_nxt;
  logic              o_full_r, o_full_nxt;
  logic [SIZE_W-1:0] o_cnt_r, o_cnt_nxt;
  logic [SIZE_W-1:0] o_size_r, o_size_nxt;

  // slot memory port
  logic                         mem_we;
  logic [skhie_pkg::ADDR_W-1:0] mem_waddr;
  skhie_pkg::entry_t            mem_wdata;
  logic [skhie_pkg::ADDR_W-1:0] mem_raddr;
  skhie_pkg::entry_t            mem_rdata;

  // modulo unit
  logic              mod_start;
  logic              mod_done;
  logic [SLOT_W-1:0] mod_rem;

  logic              accept;
  logic [NS_W-1:0]   grow;
  logic [SIZE_W-1:0] new_size;
  logic              key_hit;

  assign accept  = start && (state_r == S_IDLE);
  assign key_hit = mem_rdata.valid && (mem_rdata.key == cur_key_r);

  // four times the count, at least the base size, at most the capacity
  always_comb begin
    grow = {count_r, 2'b00};
    if (grow < NS_W'(skhie_pkg::MIN_SIZE)) begin
      grow = NS_W'(skhie_pkg::MIN_SIZE);
    end
    if (grow > NS_W'(skhie_pkg::CAPACITY)) begin
      grow = NS_W'(skhie_pkg::CAPACITY);
    end
    new_size = grow[SIZE_W-1:0];
  end

  skhie_slot_mem u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  skhie_mod_unit u_mod (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (mod_start),
    .dividend  (cur_sum_r),
    .divisor   (tgt_size_r),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  always_comb begin
    state_nxt    = state_r;
    ret_nxt      = ret_r;
    key_nxt      = key_r;
    len_nxt      = len_r;
    sum_nxt      = sum_r;
    count_nxt    = count_r;
    size_nxt     = size_r;
    bank_nxt     = bank_r;
    cur_key_nxt  = cur_key_r;
    cur_sum_nxt  = cur_sum_r;
    cur_val_nxt  = cur_val_r;
    tgt_bank_nxt = tgt_bank_r;
    tgt_size_nxt = tgt_size_r;
    rehash_nxt   = rehash_r;
    idx_nxt      = idx_r;
    probes_nxt   = probes_r;
    is_new_nxt   = is_new_r;
    full_nxt     = full_r;
    sw_bank_nxt  = sw_bank_r;
    sw_idx_nxt   = sw_idx_r;
    sw_lim_nxt   = sw_lim_r;
    scan_nxt     = scan_r;
    ov_nxt       = 1'b0;
    o_new_nxt    = o_new_r;
    o_full_nxt   = o_full_r;
    o_cnt_nxt    = o_cnt_r;
    o_size_nxt   = o_size_r;
    mem_we       = 1'b0;
    mem_waddr    = {tgt_bank_r, idx_r};
    mem_wdata    = '{valid: 1'b1, sum: cur_sum_r, value: cur_val_r, key: cur_key_r};
    mem_raddr    = {tgt_bank_r, idx_r};
    mod_start    = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_func) begin
            // clear: sweep the slots in use of the live bank
            key_nxt     = '0;
            len_nxt     = '0;
            sum_nxt     = '0;
            count_nxt   = '0;
            sw_bank_nxt = bank_r;
            sw_idx_nxt  = '0;
            sw_lim_nxt  = size_r;
            size_nxt    = SIZE_W'(skhie_pkg::BASE_SIZE);
            is_new_nxt  = 1'b0;
            full_nxt    = 1'b0;
            ret_nxt     = S_POST;
            rehash_nxt  = 1'b1;       // marks the clear result in post
            state_nxt   = S_SWEEP;
          end else begin
            if (in_key_byte != 8'd0 && len_r < LEN_W'(skhie_pkg::MAX_KEY_BYTES)) begin
              key_nxt[len_r[skhie_pkg::KIDX_W-1:0]] = in_key_byte;
              len_nxt = len_r + 1'b1;
              sum_nxt = sum_r + SUM_W'(in_key_byte);
            end
            if (in_key_last) begin
              cur_key_nxt  = key_nxt;
              cur_sum_nxt  = sum_nxt;
              cur_val_nxt  = in_value;
              tgt_bank_nxt = bank_r;
              tgt_size_nxt = size_r;
              rehash_nxt   = 1'b0;
              is_new_nxt   = 1'b0;
              full_nxt     = 1'b0;
              key_nxt      = '0;
              len_nxt      = '0;
              sum_nxt      = '0;
              state_nxt    = S_MOD_GO;
            end
          end
        end
      end

      S_SWEEP: begin
        mem_we          = 1'b1;
        mem_waddr       = {sw_bank_r, sw_idx_r};
        mem_wdata.valid = 1'b0;
        sw_idx_nxt      = sw_idx_r + 1'b1;
        if ({1'b0, sw_idx_r} + 1'b1 == sw_lim_r) begin
          state_nxt = ret_r;
        end
      end

      S_MOD_GO: begin
        mod_start = 1'b1;
        state_nxt = S_MOD_WAIT;
      end

      S_MOD_WAIT: begin
        if (mod_done) begin
          idx_nxt    = mod_rem;
          probes_nxt = '0;
          state_nxt  = S_PROBE_RD;
        end
      end

      S_PROBE_RD: begin
        state_nxt = S_PROBE_CHK;
      end

      S_PROBE_CHK: begin
        if (!mem_rdata.valid || key_hit) begin
          // free slot fills, equal key gets the new value
          mem_we = 1'b1;
          if (!mem_rdata.valid && !rehash_r) begin
            is_new_nxt = 1'b1;
            count_nxt  = count_r + 1'b1;
          end
          state_nxt = rehash_r ? S_RH_RD : S_POST;
        end else if (probes_r + 1'b1 == tgt_size_r) begin
          if (!rehash_r) begin
            full_nxt = 1'b1;
          end
          state_nxt = rehash_r ? S_RH_RD : S_POST;
        end else begin
          probes_nxt = probes_r + 1'b1;
          idx_nxt    = ({1'b0, idx_r} + 1'b1 == tgt_size_r) ? '0 : idx_r + 1'b1;
          state_nxt  = S_PROBE_RD;
        end
        // rehash: move on to the next old slot
        if (rehash_r && state_nxt == S_RH_RD) begin
          if ({1'b0, scan_r} + 1'b1 == size_r) begin
            bank_nxt   = tgt_bank_r;
            size_nxt   = tgt_size_r;
            ov_nxt     = 1'b1;
            o_new_nxt  = is_new_r;
            o_full_nxt = full_r;
            o_cnt_nxt  = count_r;
            o_size_nxt = tgt_size_r;
            state_nxt  = S_IDLE;
          end else begin
            scan_nxt = scan_r + 1'b1;
          end
        end
      end

      S_POST: begin
        if (rehash_r) begin
          // end of a clear sweep
          rehash_nxt = 1'b0;
          ov_nxt     = 1'b1;
          o_new_nxt  = 1'b0;
          o_full_nxt = 1'b0;
          o_cnt_nxt  = '0;
          o_size_nxt = size_r;
          state_nxt  = S_IDLE;
        end else if ({count_r, 1'b0} >= {1'b0, size_r}) begin
          tgt_bank_nxt = ~bank_r;
          tgt_size_nxt = new_size;
          rehash_nxt   = 1'b1;
          sw_bank_nxt  = ~bank_r;
          sw_idx_nxt   = '0;
          sw_lim_nxt   = new_size;
          scan_nxt     = '0;
          ret_nxt      = S_RH_RD;
          state_nxt    = S_SWEEP;
        end else begin
          ov_nxt     = 1'b1;
          o_new_nxt  = is_new_r;
          o_full_nxt = full_r;
          o_cnt_nxt  = count_r;
          o_size_nxt = size_r;
          state_nxt  = S_IDLE;
        end
      end

      S_RH_RD: begin
        mem_raddr = {bank_r, scan_r};
        state_nxt = S_RH_CHK;
      end

      S_RH_CHK: begin
        if (mem_rdata.valid) begin
          cur_key_nxt = mem_rdata.key;
          cur_sum_nxt = mem_rdata.sum;
          cur_val_nxt = mem_rdata.value;
          state_nxt   = S_MOD_GO;
        end else if ({1'b0, scan_r} + 1'b1 == size_r) begin
          bank_nxt   = tgt_bank_r;
          size_nxt   = tgt_size_r;
          rehash_nxt = 1'b0;
          ov_nxt     = 1'b1;
          o_new_nxt  = is_new_r;
          o_full_nxt = full_r;
          o_cnt_nxt  = count_r;
          o_size_nxt = tgt_size_r;
          state_nxt  = S_IDLE;
        end else begin
          scan_nxt  = scan_r + 1'b1;
          state_nxt = S_RH_RD;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // a rehash that ends from the probe path leaves rehash mode too
    if (state_nxt == S_IDLE && ov_nxt) begin
      rehash_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      // sweep bank 0 over the base size before the first beat
      state_r   <= S_SWEEP;
      ret_r     <= S_IDLE;
      sw_bank_r <= 1'b0;
      sw_idx_r  <= '0;
      sw_lim_r  <= SIZE_W'(skhie_pkg::BASE_SIZE);
      key_r     <= '0;
      len_r     <= '0;
      sum_r     <= '0;
      count_r   <= '0;
      size_r    <= SIZE_W'(skhie_pkg::BASE_SIZE);
      bank_r    <= 1'b0;
      rehash_r  <= 1'b0;
      ov_r      <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      ret_r     <= ret_nxt;
      sw_bank_r <= sw_bank_nxt;
      sw_idx_r  <= sw_idx_nxt;
      sw_lim_r  <= sw_lim_nxt;
      key_r     <= key_nxt;
      len_r     <= len_nxt;
      sum_r     <= sum_nxt;
      count_r   <= count_nxt;
      size_r    <= size_nxt;
      bank_r    <= bank_nxt;
      rehash_r  <= rehash_nxt;
      ov_r      <= ov_nxt;
    end
    cur_key_r  <= cur_key_nxt;
    cur_sum_r  <= cur_sum_nxt;
    cur_val_r  <= cur_val_nxt;
    tgt_bank_r <= tgt_bank_nxt;
    tgt_size_r <= tgt_size_nxt;
    idx_r      <= idx_nxt;
    probes_r   <= probes_nxt;
    is_new_r   <= is_new_nxt;
    full_r     <= full_nxt;
    scan_r     <= scan_nxt;
    o_new_r    <= o_new_nxt;
    o_full_r   <= o_full_nxt;
    o_cnt_r    <= o_cnt_nxt;
    o_size_r   <= o_size_nxt;
  end

  assign busy            = (state_r != S_IDLE);
  assign out_valid       = ov_r;
  assign out_is_new      = o_new_r;
  assign out_table_full  = o_full_r;
  assign out_entry_count = o_cnt_r;
  assign out_table_size  = o_size_r;

endmodule

@@ bench/string_key_hash_insert_engine_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// string_key_hash_insert_engine_test
// self-checking bench: keys are fed a byte per beat from a directed table and
// then at random; a typed row or else a model of the hash table gives each result
// ----------------------------------------------------------------------------
module string_key_hash_insert_engine_test;

  localparam logic FUNC_SET   = 1'b0;
  localparam logic FUNC_CLEAR = 1'b1;
  localparam int N_RANDOM   = 430;
  localparam int QUIET_TAIL = 50;       // no idling over the last items
  localparam int WD_LIMIT   = 3000000;  // cycles with no beat and no result before giving up

  typedef struct {
    logic        func;
    logic [7:0]  key_byte;
    logic        key_last;
    logic [31:0] value;
    bit          typed;   // expected result typed in below
    logic        is_new;
    logic        table_full;
    logic [10:0] entry_count;
    logic [10:0] table_size;
  } stim_row_t;

  typedef struct {
    logic        is_new;
    logic        table_full;
    logic [10:0] entry_count;
    logic [10:0] table_size;
  } insert_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        in_func = 1'b0;
  logic [7:0]  in_key_byte = 8'd0;
  logic        in_key_last = 1'b0;
  logic signed [31:0] in_value = '0;
  logic        out_valid;
  logic        out_is_new;
  logic        out_table_full;
  logic [10:0] out_entry_count;
  logic [10:0] out_table_size;

  string_key_hash_insert_engine u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_func(in_func), .in_key_byte(in_key_byte), .in_key_last(in_key_last),
    .in_value(in_value), .out_valid(out_valid), .out_is_new(out_is_new),
    .out_table_full(out_table_full), .out_entry_count(out_entry_count),
    .out_table_size(out_table_size)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // hash table model: two banks of CAPACITY slots, same walk as the block
  // ---------------------------------------------------------------------------
  logic [7:0]       gather_buf [skhie_pkg::MAX_KEY_BYTES];
  int unsigned      gather_len;
  bit               tbl_valid [skhie_pkg::DEPTH];
  int unsigned      tbl_hash  [skhie_pkg::DEPTH];
  logic [31:0]      tbl_value [skhie_pkg::DEPTH];
  skhie_pkg::key_t  tbl_key   [skhie_pkg::DEPTH];
  int unsigned      tbl_count;
  int unsigned      tbl_size;
  int unsigned      tbl_bank;

  insert_result_t pending_results [$];
  stim_row_t      stim_table [$];
  int             err_count = 0;

  function automatic int unsigned byte_sum_hash(skhie_pkg::key_t k, int unsigned size);
    int unsigned s;
    s = 0;
    for (int i = 0; i < skhie_pkg::MAX_KEY_BYTES; i++) s += k[i];
    return s % size;
  endfunction

  // returns 1 when no slot is free and the key is not found
  function automatic bit probe_place(int unsigned bank, int unsigned size,
                                     skhie_pkg::key_t k, logic [31:0] v,
                                     output bit fresh);
    int unsigned h, idx, s;
    h = byte_sum_hash(k, size);
    fresh = 1'b0;
    for (int unsigned n = 0; n < size; n++) begin
      idx = h + n;
      if (idx >= size) idx -= size;
      s = bank * skhie_pkg::CAPACITY + idx;
      if (!tbl_valid[s]) begin
        tbl_valid[s] = 1'b1;
        tbl_hash[s]  = h;
        tbl_value[s] = v;
        tbl_key[s]   = k;
        fresh = 1'b1;
        return 1'b0;
      end
      if (tbl_hash[s] == h && tbl_key[s] == k) begin
        tbl_value[s] = v;
        return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  function automatic void grow_into_other_bank();
    int unsigned from, to, nsize, s;
    bit dummy;
    from = tbl_bank;
    to = from ^ 1;
    nsize = tbl_count * 4;
    if (nsize < skhie_pkg::MIN_SIZE) nsize = skhie_pkg::MIN_SIZE;
    if (nsize > skhie_pkg::CAPACITY) nsize = skhie_pkg::CAPACITY;
    for (int i = 0; i < skhie_pkg::CAPACITY; i++)
      tbl_valid[to * skhie_pkg::CAPACITY + i] = 1'b0;
    for (int unsigned i = 0; i < tbl_size && i < skhie_pkg::CAPACITY; i++) begin
      s = from * skhie_pkg::CAPACITY + i;
      if (tbl_valid[s]) void'(probe_place(to, nsize, tbl_key[s], tbl_value[s], dummy));
    end
    for (int i = 0; i < skhie_pkg::CAPACITY; i++)
      tbl_valid[from * skhie_pkg::CAPACITY + i] = 1'b0;
    tbl_bank = to;
    tbl_size = nsize;
  endfunction

  function automatic void clear_table_model();
    for (int i = 0; i < skhie_pkg::DEPTH; i++) tbl_valid[i] = 1'b0;
    tbl_count = 0;
    tbl_size = skhie_pkg::BASE_SIZE;
    gather_len = 0;
  endfunction

  // one accepted beat; returns 1 and the result when the beat completes an op
  function automatic bit predict_insert(logic func, logic [7:0] kb, logic last,
                                        logic [31:0] v, output insert_result_t r);
    skhie_pkg::key_t k;
    bit fresh, full;
    fresh = 1'b0;
    full = 1'b0;
    if (func == FUNC_CLEAR) begin
      clear_table_model();
    end else begin
      if (kb != 8'd0 && gather_len < skhie_pkg::MAX_KEY_BYTES) begin
        gather_buf[gather_len] = kb;
        gather_len++;
      end
      if (!last) return 1'b0;
      k = '0;
      for (int unsigned i = 0; i < gather_len; i++) k[i] = gather_buf[i];
      gather_len = 0;
      full = probe_place(tbl_bank, tbl_size, k, v, fresh);
      if (fresh) tbl_count++;
      if (tbl_count * 2 >= tbl_size) grow_into_other_bank();
    end
    r.is_new      = fresh;
    r.table_full  = full;
    r.entry_count = tbl_count[10:0];
    r.table_size  = tbl_size[10:0];
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // driver: fields change on the falling edge, acceptance seen on the rising
  // ---------------------------------------------------------------------------
  bit idle_ok = 1'b1;

  task automatic send_beat(stim_row_t row);
    insert_result_t r;
    int gap;
    @(negedge clk);
    if (idle_ok && $urandom_range(0, 5) == 0) begin
      // idle burst before this beat
      start <= 1'b0;
      gap = $urandom_range(1, 18);
      repeat (gap) @(negedge clk);
    end
    start       <= 1'b1;
    in_func     <= row.func;
    in_key_byte <= row.key_byte;
    in_key_last <= row.key_last;
    in_value    <= row.value;
    @(posedge clk);
    while (busy) @(posedge clk);
    // beat accepted at this edge
    if (predict_insert(row.func, row.key_byte, row.key_last, row.value, r)) begin
      if (row.typed) begin
        r.is_new      = row.is_new;
        r.table_full  = row.table_full;
        r.entry_count = row.entry_count;
        r.table_size  = row.table_size;
      end
      pending_results.push_back(r);
    end
  endtask

  function automatic stim_row_t mk_row(logic func, logic [7:0] kb, logic last,
                                       logic [31:0] v);
    stim_row_t row;
    row.func = func; row.key_byte = kb; row.key_last = last; row.value = v;
    row.typed = 1'b0;
    row.is_new = 1'b0; row.table_full = 1'b0;
    row.entry_count = '0; row.table_size = '0;
    return row;
  endfunction

  function automatic stim_row_t mk_typed(stim_row_t row, logic nw, logic fl,
                                         int cnt, int sz);
    row.typed = 1'b1;
    row.is_new = nw; row.table_full = fl;
    row.entry_count = cnt[10:0]; row.table_size = sz[10:0];
    return row;
  endfunction

  // random key: mostly short keys over a tiny alphabet so overwrites happen
  task automatic send_random_key();
    int len;
    logic [7:0] kb;
    stim_row_t row;
    len = ($urandom_range(0, 15) == 0) ? $urandom_range(14, 20) : $urandom_range(1, 3);
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(0, 9))
        0: kb = 8'd255;
        1: kb = 8'($urandom_range(1, 255));
        2: kb = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'd128;
        default: kb = 8'($urandom_range(1, 4));
      endcase
      row = mk_row(FUNC_SET, kb, (i == len - 1), $urandom());
      // occasional clear in the middle of a key
      if (i != len - 1 && $urandom_range(0, 60) == 0)
        row = mk_row(FUNC_CLEAR, 8'($urandom()), 1'($urandom()), $urandom());
      send_beat(row);
      if (row.func == FUNC_CLEAR) break;
    end
  endtask

  // ---------------------------------------------------------------------------
  // result checker
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    insert_result_t e;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $error("result with nothing expected: count %0d size %0d",
               out_entry_count, out_table_size);
        err_count++;
      end else begin
        e = pending_results.pop_front();
        if (out_is_new !== e.is_new) begin
          $error("is_new: expected %0d, got %0d", e.is_new, out_is_new);
          err_count++;
        end
        if (out_table_full !== e.table_full) begin
          $error("table_full: expected %0d, got %0d", e.table_full, out_table_full);
          err_count++;
        end
        if (out_entry_count !== e.entry_count) begin
          $error("entry_count: expected %0d, got %0d", e.entry_count, out_entry_count);
          err_count++;
        end
        if (out_table_size !== e.table_size) begin
          $error("table_size: expected %0d, got %0d", e.table_size, out_table_size);
          err_count++;
        end
      end
    end
  end

  // watchdog: cycles in which neither a beat nor a result moves
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WD_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin
    int wait_cycles;
    for (int i = 0; i < skhie_pkg::MAX_KEY_BYTES; i++) gather_buf[i] = '0;
    for (int i = 0; i < skhie_pkg::DEPTH; i++) begin
      tbl_valid[i] = 1'b0; tbl_hash[i] = 0; tbl_value[i] = '0; tbl_key[i] = '0;
    end
    tbl_bank = 0;
    clear_table_model();

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed table
    // empty key (zero byte with last) right after reset, then overwrite it
    stim_table.push_back(mk_typed(mk_row(FUNC_SET, 8'd0, 1'b1, 32'h0),
                                  1'b1, 1'b0, 1, 10));
    stim_table.push_back(mk_typed(mk_row(FUNC_SET, 8'd0, 1'b1, 32'hFFFF_FFFF),
                                  1'b0, 1'b0, 1, 10));
    // extreme byte and value extremes
    stim_table.push_back(mk_row(FUNC_SET, 8'd255, 1'b1, 32'h7FFF_FFFF));
    stim_table.push_back(mk_row(FUNC_SET, 8'd1, 1'b0, 32'h8000_0000));
    stim_table.push_back(mk_row(FUNC_SET, 8'd0, 1'b1, 32'h8000_0000));
    // fifth key triggers the first grow
    stim_table.push_back(mk_row(FUNC_SET, 8'd10, 1'b1, 32'h1234_5678));
    stim_table.push_back(mk_row(FUNC_SET, 8'd20, 1'b1, 32'hA5A5_A5A5));
    // long key, truncated after MAX_KEY_BYTES bytes
    for (int i = 0; i < 17; i++)
      stim_table.push_back(mk_row(FUNC_SET, 8'd122, (i == 16), 32'(i)));
    // half a key then clear: partial key discarded
    stim_table.push_back(mk_row(FUNC_SET, 8'd7, 1'b0, 32'h0));
    stim_table.push_back(mk_typed(mk_row(FUNC_CLEAR, 8'hFF, 1'b1, 32'hFFFF_FFFF),
                                  1'b0, 1'b0, 0, skhie_pkg::BASE_SIZE));
    stim_table.push_back(mk_typed(mk_row(FUNC_SET, 8'd0, 1'b1, 32'h5),
                                  1'b1, 1'b0, 1, 10));

    foreach (stim_table[i]) send_beat(stim_table[i]);

    // random part
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n >= N_RANDOM - QUIET_TAIL) idle_ok = 1'b0;
      if ($urandom_range(0, 40) == 0)
        send_beat(mk_row(FUNC_CLEAR, 8'($urandom()), 1'($urandom()), $urandom()));
      else
        send_random_key();
    end

    @(negedge clk);
    start <= 1'b0;

    // drain outstanding results, then let the block settle
    wait_cycles = 0;
    while (pending_results.size() != 0 && wait_cycles < WD_LIMIT) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (100) @(posedge clk);

    if (err_count == 0 && pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
